@@ sv/case_insensitive_substring_matcher_macros.svh @@
// assertion macros for the case-insensitive substring matcher
// included by the top level; no other dependencies
`ifndef CASE_INSENSITIVE_SUBSTRING_MATCHER_MACROS_SVH
`define CASE_INSENSITIVE_SUBSTRING_MATCHER_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define CISM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define CISM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/cism_pkg.sv @@
// shared types and constants for the case-insensitive substring matcher
// no dependencies
package cism_pkg;

   // window and needle depth
   localparam int MAX_NEEDLE = 32;
   localparam int IDX_W      = $clog2(MAX_NEEDLE);
   localparam int LEN_W      = 6;
   localparam int OP_W       = 2;
   localparam int CHAR_W     = 8;

   // operation codes
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_TEXT  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

   typedef logic [CHAR_W-1:0] char_type;
   typedef char_type [MAX_NEEDLE-1:0] row_type;

   // per-cycle control broadcast to every cell
   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctl_type;

endpackage

@@ sv/cism_cell.sv @@
// one cell of the matcher chain: a window byte, a needle byte and its comparator
// depends on cism_pkg
module cism_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  cism_pkg::cell_ctl_type ctl,
   input  cism_pkg::char_type    newer_byte,
   output cism_pkg::char_type    window_byte,
   input  logic                  needle_we,
   input  cism_pkg::char_type    needle_data,
   output cism_pkg::char_type    needle_byte,
   input  cism_pkg::char_type    aligned_needle,
   input  logic                  active,
   output logic                  hit
);
   import cism_pkg::*;

   char_type window_ff;
   char_type window_in;
   char_type needle_ff;
   char_type needle_in;

   // window byte moves one cell older per text transaction; a clear zeroes it
   always_comb begin
      priority if (ctl.clear) begin
         window_in = '0;
      end else if (ctl.shift) begin
         window_in = newer_byte;
      end else begin
         window_in = window_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else begin
         window_ff <= window_in;
      end
   end

   // needle byte, undefined until loaded
   assign needle_in = needle_we ? needle_data : needle_ff;

   always_ff @(posedge clock) begin
      needle_ff <= needle_in;
   end

   // compare the byte this cell will hold after the shift
   assign hit         = !active || (newer_byte == aligned_needle);
   assign window_byte = window_ff;
   assign needle_byte = needle_ff;

endmodule

@@ sv/cism_rot.sv @@
// barrel rotator that lines the needle up with the newest end of the window
// depends on cism_pkg
module cism_rot (
   input  cism_pkg::row_type                 needle_row,
   input  logic [cism_pkg::IDX_W-1:0]        amount,
   output cism_pkg::row_type                 aligned_row
);
   import cism_pkg::*;

   row_type stage [0:IDX_W];

   assign stage[0] = needle_row;

   // aligned[p] = needle[(p + amount) mod depth], one power of two per level
   for (genvar k = 0; k < IDX_W; k++) begin : g_level
      for (genvar p = 0; p < MAX_NEEDLE; p++) begin : g_pos
         localparam int SRC = (p + (1 << k)) % MAX_NEEDLE;
         assign stage[k+1][p] = amount[k] ? stage[k][SRC] : stage[k][p];
      end
   end

   assign aligned_row = stage[IDX_W];

endmodule

@@ sv/case_insensitive_substring_matcher.sv @@
// Streaming case-insensitive substring matcher (top level; uses cism_pkg, cism_cell,
// cism_rot and the assertion macro header). A needle of up to 32 bytes is loaded by
// index, text bytes stream through a row of 32 cells that shift the window one cell
// per text transaction, and every cell compares its new byte against the rotated
// needle in parallel. One transaction is accepted per clock cycle, back to back, and
// its result appears in the next cycle from the output register; a result that is
// not taken holds off further requests. A result that waits does not stop the next
// transaction as long as the consumer takes it in the same cycle.
`include "case_insensitive_substring_matcher_macros.svh"

module case_insensitive_substring_matcher (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [cism_pkg::OP_W-1:0]     req_operation,
   input  logic [cism_pkg::IDX_W-1:0]    req_byte_index,
   input  logic [cism_pkg::CHAR_W-1:0]   req_byte_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_match_here,
   output logic                          rsp_found,
   input  logic                          csr_write_enable,
   input  logic [cism_pkg::LEN_W-1:0]    csr_write_data
);
   import cism_pkg::*;

   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'd32;
   localparam logic [LEN_W-1:0]  LEN_MAX      = LEN_W'(MAX_NEEDLE);

   function automatic char_type fold_upper(input char_type c);
      char_type r;
      r = c;
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         r = c - CASE_OFFSET;
      end
      return r;
   endfunction

   logic              accept;
   logic              is_load;
   logic              is_text;
   logic              is_clear;
   char_type          folded;
   cell_ctl_type      ctl;
   row_type           window_row;
   row_type           newer_row;
   row_type           needle_row;
   row_type           aligned_row;
   logic [MAX_NEEDLE-1:0] needle_we;
   logic [MAX_NEEDLE-1:0] active;
   logic [MAX_NEEDLE-1:0] hit;

   logic [LEN_W-1:0]  len_ff;
   logic [LEN_W-1:0]  len_in;
   logic [LEN_W-1:0]  bytes_seen_ff;
   logic [LEN_W-1:0]  bytes_seen_in;
   logic [LEN_W-1:0]  seen_inc;
   logic              found_flag_ff;
   logic              found_flag_in;
   logic              len_usable;
   logic              text_match;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              rsp_match_ff;
   logic              rsp_match_in;
   logic              rsp_found_ff;
   logic              rsp_found_in;

   // handshake: the output register frees up when its transaction is taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // operation decode
   always_comb begin
      is_load  = 1'b0;
      is_text  = 1'b0;
      is_clear = 1'b0;
      unique case (req_operation)
         OP_LOAD:  is_load  = accept;
         OP_TEXT:  is_text  = accept;
         OP_CLEAR: is_clear = accept;
         OP_NONE:  ;
      endcase
   end

   assign folded    = fold_upper(req_byte_value);
   assign ctl.shift = is_text;
   assign ctl.clear = is_clear;

   // needle length register
   assign len_in = csr_write_enable ? csr_write_data : len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
   end

   // line the needle up so its last byte meets the newest window cell
   cism_rot u_rot (
      .needle_row  (needle_row),
      .amount      (len_ff[IDX_W-1:0]),
      .aligned_row (aligned_row)
   );

   // row of cells, newest byte enters at the top cell
   for (genvar p = 0; p < MAX_NEEDLE; p++) begin : g_cell
      if (p == MAX_NEEDLE - 1) begin : g_top
         assign newer_row[p] = folded;
      end else begin : g_mid
         assign newer_row[p] = window_row[p+1];
      end

      assign needle_we[p] = is_load && (req_byte_index == IDX_W'(p));
      // cell takes part when it lies within the last len_ff window positions
      assign active[p] = ((LEN_W+1)'(p) + {1'b0, len_ff}) >= (LEN_W+1)'(MAX_NEEDLE);

      cism_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctl            (ctl),
         .newer_byte     (newer_row[p]),
         .window_byte    (window_row[p]),
         .needle_we      (needle_we[p]),
         .needle_data    (folded),
         .needle_byte    (needle_row[p]),
         .aligned_needle (aligned_row[p]),
         .active         (active[p]),
         .hit            (hit[p])
      );
   end

   // match decision for a text transaction
   assign seen_inc   = (bytes_seen_ff < LEN_MAX) ? bytes_seen_ff + 1'b1 : bytes_seen_ff;
   assign len_usable = (len_ff != '0) && (len_ff <= LEN_MAX);
   assign text_match = len_usable && (seen_inc >= len_ff) && (&hit);

   // search progress
   always_comb begin
      bytes_seen_in = bytes_seen_ff;
      found_flag_in = found_flag_ff;
      priority if (is_clear) begin
         bytes_seen_in = '0;
         found_flag_in = 1'b0;
      end else if (is_text) begin
         bytes_seen_in = seen_inc;
         found_flag_in = found_flag_ff || text_match;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= '0;
         found_flag_ff <= 1'b0;
      end else begin
         bytes_seen_ff <= bytes_seen_in;
         found_flag_ff <= found_flag_in;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_match_in = rsp_match_ff;
      rsp_found_in = rsp_found_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_match_in = is_text && text_match;
         rsp_found_in = found_flag_in || (len_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_match_ff <= rsp_match_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_match_here = rsp_match_ff;
   assign rsp_found      = rsp_found_ff;

   // checks
   `CISM_ASSERT_NOW(a_match_sets_found, clock, reset, rsp_valid_ff && rsp_match_ff, rsp_found_ff, "match reported without found")
   `CISM_ASSERT_NEXT(a_clear_empties, clock, reset, is_clear, (bytes_seen_ff == '0) && !found_flag_ff, "clear did not reset the search")
   `CISM_ASSERT_NOW(a_seen_bounded, clock, reset, 1'b1, bytes_seen_ff <= LEN_MAX, "byte count past the window depth")
   `CISM_ASSERT_NEXT(a_accept_gives_result, clock, reset, accept, rsp_valid_ff, "accepted transaction produced no result")

endmodule
